// ===== hdl/fcd_pkg.sv =====
// fcd_pkg: shared types, constants and helpers of the framed command deframer
package fcd_pkg;

  localparam int unsigned PORTS = 24;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  localparam logic [7:0]  HASH_CHAR       = 8'h23;
  localparam logic [15:0] MAX_LENGTH_RST  = 16'd1024;

  localparam logic [15:0] OPC_NO_ARG = 16'h0001;
  localparam logic [15:0] OPC_RESET  = 16'hDEAD;
  localparam logic [15:0] OPC_TAG    = 16'h0002;
  localparam logic [15:0] OPC_STATUS = 16'h0006;
  localparam logic [15:0] OPC_CONFIG = 16'h0007;

  localparam logic [15:0] TAG_COUNT    = 16'd4;
  localparam logic [15:0] CONFIG_COUNT = 16'(4 + 2 * PORTS);

  typedef logic [7:0]  byte_t;
  typedef logic [15:0] word_t;
  typedef logic [9:0]  idx_t;

  typedef enum logic [8:0] {
    PH_HASH1   = 9'b000000001,
    PH_HASH2   = 9'b000000010,
    PH_OPC_LO  = 9'b000000100,
    PH_OPC_HI  = 9'b000001000,
    PH_LEN_LO  = 9'b000010000,
    PH_LEN_HI  = 9'b000100000,
    PH_PAYLOAD = 9'b001000000,
    PH_CK_LO   = 9'b010000000,
    PH_CK_HI   = 9'b100000000
  } phase_t;

  typedef enum logic [1:0] {
    EV_DATA   = 2'd0,
    EV_GOOD   = 2'd1,
    EV_BAD    = 2'd2,
    EV_REJECT = 2'd3
  } ev_t;

  typedef enum logic [1:0] {
    REC_DATA   = 2'd0,
    REC_CHECK  = 2'd1,
    REC_REJECT = 2'd2
  } rec_kind_t;

  // one classified record handed from the parser to the result stage
  typedef struct packed {
    rec_kind_t kind;
    word_t     opcode;
    byte_t     data;
    idx_t      index;
    word_t     rx_sum;
    word_t     calc_sum;
  } rec_t;

  function automatic word_t payload_count(input word_t opc, input word_t len);
    word_t cnt;
    if (opc == OPC_NO_ARG || opc == OPC_RESET) cnt = '0;
    else if (opc == OPC_TAG || opc == OPC_STATUS) cnt = TAG_COUNT;
    else if (opc == OPC_CONFIG) cnt = CONFIG_COUNT;
    else cnt = len;
    return cnt;
  endfunction

endpackage

// ===== hdl/fcd_in_if.sv =====
// fcd_in_if: received byte channel
interface fcd_in_if;
  import fcd_pkg::*;
  logic  valid;
  logic  ready;
  byte_t rx_byte;
  logic  timeout;

  modport source (output valid, output rx_byte, output timeout, input ready);
  modport sink   (input valid, input rx_byte, input timeout, output ready);
endinterface

// ===== hdl/fcd_out_if.sv =====
// fcd_out_if: result event channel
interface fcd_out_if;
  import fcd_pkg::*;
  logic       valid;
  logic       ready;
  logic [1:0] event_res;
  word_t      frame_opcode;
  byte_t      payload_byte;
  idx_t       payload_index;

  modport source (output valid, output event_res, output frame_opcode,
                  output payload_byte, output payload_index, input ready);
  modport sink   (input valid, input event_res, input frame_opcode,
                  input payload_byte, input payload_index, output ready);
endinterface

// ===== hdl/fcd_cfg_if.sv =====
// fcd_cfg_if: max_length register write channel
interface fcd_cfg_if;
  import fcd_pkg::*;
  logic  valid;
  logic  ready;
  word_t max_length;

  modport source (output valid, output max_length, input ready);
  modport sink   (input valid, input max_length, output ready);
endinterface

// ===== hdl/framed_command_deframer.sv =====
// framed_command_deframer: top level joining parser, record queue and result stage
// a result passes the record queue, then the output register that drives out
// throughput: one byte per cycle; in stalls only when the record queue is full
// the queue depth sets how long out may stall before in backs up
// reset: synchronous rst_n returns the parser to hash search, empties the queue,
// drops any pending result and loads max_length with 1024
module framed_command_deframer #(
  parameter int unsigned QUEUE_DEPTH = fcd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  fcd_in_if.sink    in_ch,
  fcd_out_if.source out_ch,
  fcd_cfg_if.sink   cfg_ch
);
  import fcd_pkg::*;

  word_t max_length_r;
  logic  push_valid;
  logic  push_ready;
  rec_t  push_rec;
  logic  pop_valid;
  logic  pop_ready;
  rec_t  pop_rec;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_length_r <= MAX_LENGTH_RST;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      max_length_r <= cfg_ch.max_length;
    end
  end

  fcd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .max_length (max_length_r),
    .push_ready (push_ready),
    .push_valid (push_valid),
    .push_rec   (push_rec)
  );

  fcd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_rec   (push_rec),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_rec    (pop_rec)
  );

  fcd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_rec   (pop_rec),
    .out_ch    (out_ch)
  );

`ifndef SYNTHESIS
  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    push_valid |-> push_ready)
    else $error("record pushed into a full queue");

  a_timeout_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.timeout) |-> !push_valid)
    else $error("timeout beat produced a record");

  a_pop_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
    (pop_valid && pop_ready) |=> out_ch.valid)
    else $error("popped record did not reach the output register");

  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_ch.valid && cfg_ch.ready) |=> (max_length_r == $past(cfg_ch.max_length)))
    else $error("max_length write lost");
`endif

endmodule

// ===== hdl/fcd_front.sv =====
// fcd_front: byte parser that tracks the frame phase and classifies each byte
module fcd_front (
  input  logic         clk,
  input  logic         rst_n,
  fcd_in_if.sink       in_ch,
  input  fcd_pkg::word_t max_length,
  input  logic         push_ready,
  output logic         push_valid,
  output fcd_pkg::rec_t push_rec
);
  import fcd_pkg::*;

  phase_t phase_r, phase_nxt;
  byte_t  low_r, low_nxt;
  word_t  sum_r, sum_nxt;
  word_t  opc_r, opc_nxt;
  word_t  left_r, left_nxt;
  idx_t   pos_r, pos_nxt;

  byte_t  b;
  word_t  field_w;
  word_t  sum_add;
  word_t  left_dec;
  word_t  count_w;

  assign in_ch.ready = push_ready;
  assign b        = in_ch.rx_byte;
  assign field_w  = {b, low_r};
  assign sum_add  = sum_r + word_t'(b);
  assign left_dec = left_r - 16'd1;
  assign count_w  = payload_count(opc_r, field_w);

  always_comb begin
    phase_nxt  = phase_r;
    low_nxt    = low_r;
    sum_nxt    = sum_r;
    opc_nxt    = opc_r;
    left_nxt   = left_r;
    pos_nxt    = pos_r;
    push_valid = 1'b0;
    push_rec   = '0;
    push_rec.opcode = opc_r;
    if (in_ch.valid && in_ch.ready) begin
      if (in_ch.timeout) begin
        phase_nxt = PH_HASH1;
      end else begin
        unique case (phase_r)
          PH_HASH2: begin
            if (b == HASH_CHAR) begin
              sum_nxt   = word_t'(HASH_CHAR) + word_t'(HASH_CHAR);
              phase_nxt = PH_OPC_LO;
            end else begin
              phase_nxt = PH_HASH1;
            end
          end
          PH_OPC_LO: begin
            low_nxt   = b;
            sum_nxt   = sum_add;
            phase_nxt = PH_OPC_HI;
          end
          PH_OPC_HI: begin
            opc_nxt   = field_w;
            sum_nxt   = sum_add;
            phase_nxt = PH_LEN_LO;
          end
          PH_LEN_LO: begin
            low_nxt   = b;
            sum_nxt   = sum_add;
            phase_nxt = PH_LEN_HI;
          end
          PH_LEN_HI: begin
            sum_nxt = sum_add;
            if (field_w > max_length) begin
              push_valid    = 1'b1;
              push_rec.kind = REC_REJECT;
              phase_nxt     = PH_HASH1;
            end else begin
              left_nxt  = count_w;
              pos_nxt   = '0;
              phase_nxt = (count_w == '0) ? PH_CK_LO : PH_PAYLOAD;
            end
          end
          PH_PAYLOAD: begin
            push_valid     = 1'b1;
            push_rec.kind  = REC_DATA;
            push_rec.data  = b;
            push_rec.index = pos_r;
            sum_nxt        = sum_add;
            pos_nxt        = pos_r + idx_t'(1);
            left_nxt       = left_dec;
            if (left_dec == '0) phase_nxt = PH_CK_LO;
          end
          PH_CK_LO: begin
            low_nxt   = b;
            phase_nxt = PH_CK_HI;
          end
          PH_CK_HI: begin
            push_valid        = 1'b1;
            push_rec.kind     = REC_CHECK;
            push_rec.rx_sum   = field_w;
            push_rec.calc_sum = sum_r;
            phase_nxt         = PH_HASH1;
          end
          default: begin
            phase_nxt = (b == HASH_CHAR) ? PH_HASH2 : PH_HASH1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HASH1;
      low_r   <= '0;
      sum_r   <= '0;
      opc_r   <= '0;
      left_r  <= '0;
      pos_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      low_r   <= low_nxt;
      sum_r   <= sum_nxt;
      opc_r   <= opc_nxt;
      left_r  <= left_nxt;
      pos_r   <= pos_nxt;
    end
  end

endmodule

// ===== hdl/fcd_queue.sv =====
// fcd_queue: short record queue between parser and result stage
module fcd_queue #(
  parameter int unsigned DEPTH = fcd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  fcd_pkg::rec_t push_rec,
  output logic          pop_valid,
  input  logic          pop_ready,
  output fcd_pkg::rec_t pop_rec
);
  import fcd_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  rec_t            mem_r [DEPTH];
  logic [PW-1:0]   wr_r, wr_nxt;
  logic [PW-1:0]   rd_r, rd_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            do_push;
  logic            do_pop;

  assign push_ready = (cnt_r != FULL);
  assign pop_valid  = (cnt_r != '0);
  assign pop_rec    = mem_r[rd_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) wr_nxt = (wr_r == LAST) ? '0 : wr_r + PW'(1);
    if (do_pop)  rd_nxt = (rd_r == LAST) ? '0 : rd_r + PW'(1);
    if (do_push && !do_pop) cnt_nxt = cnt_r + CW'(1);
    else if (do_pop && !do_push) cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_r] <= push_rec;
  end

endmodule

// ===== hdl/fcd_back.sv =====
// fcd_back: result stage that resolves records into events and holds the output register
module fcd_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          pop_valid,
  output logic          pop_ready,
  input  fcd_pkg::rec_t pop_rec,
  fcd_out_if.source     out_ch
);
  import fcd_pkg::*;

  logic  valid_r;
  ev_t   ev_r, ev_nxt;
  word_t opc_r;
  byte_t data_r, data_nxt;
  idx_t  idx_r, idx_nxt;
  logic  load;

  assign pop_ready = !valid_r || out_ch.ready;
  assign load      = pop_valid && pop_ready;

  always_comb begin
    data_nxt = '0;
    idx_nxt  = '0;
    unique case (pop_rec.kind)
      REC_DATA: begin
        ev_nxt   = EV_DATA;
        data_nxt = pop_rec.data;
        idx_nxt  = pop_rec.index;
      end
      REC_CHECK: ev_nxt = (pop_rec.rx_sum == pop_rec.calc_sum) ? EV_GOOD : EV_BAD;
      default:   ev_nxt = EV_REJECT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop_ready) begin
      valid_r <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ev_r   <= ev_nxt;
      opc_r  <= pop_rec.opcode;
      data_r <= data_nxt;
      idx_r  <= idx_nxt;
    end
  end

  assign out_ch.valid         = valid_r;
  assign out_ch.event_res     = ev_r;
  assign out_ch.frame_opcode  = opc_r;
  assign out_ch.payload_byte  = data_r;
  assign out_ch.payload_index = idx_r;

endmodule

// ===== dv/tb_top.sv =====
// tb_top: self-checking testbench for the framed command deframer
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import fcd_pkg::*;

  typedef struct packed {
    byte_t rx_byte;
    logic  timeout;
  } rx_beat_t;

  typedef struct packed {
    ev_t   ev;
    word_t opcode;
    byte_t data;
    idx_t  index;
  } deframe_event_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_fire = 1'b0;

  fcd_in_if  in_if();
  fcd_out_if out_if();
  fcd_cfg_if cfg_if();

  framed_command_deframer u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  rx_beat_t       byte_feed[$];
  deframe_event_t expected_events[$];
  byte_t          frame_buf[$];

  int    bytes_queued = 0;
  int    cfg_beats = 0;
  int    mismatches = 0;
  int    tx_idle_pct = 0;
  int    rx_idle_pct = 0;
  int    rx_hold_req = 0;
  int    rx_hold_seen = 0;
  int    rx_hold_left = 0;
  word_t cur_max = MAX_LENGTH_RST;

  // predictor state
  phase_t prd_phase;
  byte_t  prd_low;
  word_t  prd_sum;
  word_t  prd_opcode;
  word_t  prd_length;
  word_t  prd_left;
  idx_t   prd_pos;
  word_t  prd_limit;

  function automatic word_t frame_body_count(input word_t opc, input word_t len);
    if (opc == OPC_NO_ARG || opc == OPC_RESET) return 16'd0;
    if (opc == OPC_TAG || opc == OPC_STATUS) return 16'd4;
    if (opc == OPC_CONFIG) return word_t'(4 + 2 * PORTS);
    return len;
  endfunction

  function automatic void note_event(input ev_t ev, input byte_t data, input idx_t idx);
    expected_events.push_back('{ev, prd_opcode, data, idx});
  endfunction

  function automatic void deframe_byte(input byte_t b, input logic to);
    idx_t  idx;
    word_t rx_ck;
    if (to) begin
      prd_phase = PH_HASH1;
      return;
    end
    case (prd_phase)
      PH_HASH2: begin
        if (b == HASH_CHAR) begin
          prd_sum = word_t'(HASH_CHAR) + word_t'(HASH_CHAR);
          prd_phase = PH_OPC_LO;
        end else begin
          prd_phase = PH_HASH1;
        end
      end
      PH_OPC_LO: begin
        prd_low = b;
        prd_sum = prd_sum + word_t'(b);
        prd_phase = PH_OPC_HI;
      end
      PH_OPC_HI: begin
        prd_opcode = {b, prd_low};
        prd_sum = prd_sum + word_t'(b);
        prd_phase = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        prd_low = b;
        prd_sum = prd_sum + word_t'(b);
        prd_phase = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        prd_length = {b, prd_low};
        prd_sum = prd_sum + word_t'(b);
        if (prd_length > prd_limit) begin
          prd_phase = PH_HASH1;
          note_event(EV_REJECT, 8'd0, 10'd0);
        end else begin
          prd_left = frame_body_count(prd_opcode, prd_length);
          prd_pos = '0;
          prd_phase = (prd_left == 16'd0) ? PH_CK_LO : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        idx = prd_pos;
        prd_sum = prd_sum + word_t'(b);
        prd_pos = prd_pos + 10'd1;
        prd_left = prd_left - 16'd1;
        if (prd_left == 16'd0) prd_phase = PH_CK_LO;
        note_event(EV_DATA, b, idx);
      end
      PH_CK_LO: begin
        prd_low = b;
        prd_phase = PH_CK_HI;
      end
      PH_CK_HI: begin
        rx_ck = {b, prd_low};
        prd_phase = PH_HASH1;
        note_event((rx_ck == prd_sum) ? EV_GOOD : EV_BAD, 8'd0, 10'd0);
      end
      default: prd_phase = (b == HASH_CHAR) ? PH_HASH2 : PH_HASH1;
    endcase
  endfunction

  // clock
  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #(2_000_000);
    $display("FAIL");
    $finish;
  end

  // byte driver
  always @(negedge clk) begin : drive_bytes
    rx_beat_t nxt;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_fire) begin
      if (byte_feed.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        nxt = byte_feed.pop_front();
        in_if.valid <= 1'b1;
        in_if.rx_byte <= nxt.rx_byte;
        in_if.timeout <= nxt.timeout;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // result receiver, with an occasional long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (rx_hold_seen != rx_hold_req) begin
      rx_hold_seen <= rx_hold_req;
      rx_hold_left <= 400;
      out_if.ready <= 1'b0;
    end else if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // monitor: config beats, byte beats into the predictor, result beats against it
  always @(posedge clk) begin : watch_beats
    deframe_event_t want;
    if (!rst_n) begin
      in_fire <= 1'b0;
      prd_phase = PH_HASH1;
      prd_low = '0;
      prd_sum = '0;
      prd_opcode = '0;
      prd_length = '0;
      prd_left = '0;
      prd_pos = '0;
      prd_limit = MAX_LENGTH_RST;
    end else begin
      in_fire <= in_if.valid && in_if.ready;
      if (cfg_if.valid && cfg_if.ready) begin
        prd_limit = cfg_if.max_length;
        cfg_beats <= cfg_beats + 1;
      end
      if (out_if.valid && out_if.ready) begin
        if (expected_events.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result beat: ev=%0d opc=%h data=%h idx=%0d",
                     out_if.event_res, out_if.frame_opcode, out_if.payload_byte,
                     out_if.payload_index);
        end else begin
          want = expected_events.pop_front();
          if (out_if.event_res !== want.ev || out_if.frame_opcode !== want.opcode ||
              out_if.payload_byte !== want.data || out_if.payload_index !== want.index) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: expected ev=%0d opc=%h data=%h idx=%0d, ",
                        "got ev=%0d opc=%h data=%h idx=%0d"},
                       want.ev, want.opcode, want.data, want.index, out_if.event_res,
                       out_if.frame_opcode, out_if.payload_byte, out_if.payload_index);
          end
        end
      end
      if (in_if.valid && in_if.ready) deframe_byte(in_if.rx_byte, in_if.timeout);
    end
  end

  task automatic queue_byte(input byte_t b, input logic to);
    byte_feed.push_back('{b, to});
    bytes_queued++;
  endtask

  function automatic void add_frame_byte(input byte_t b, inout word_t ck);
    frame_buf.push_back(b);
    ck = ck + word_t'(b);
  endfunction

  // whole frame into frame_buf; a rejected length ends the frame after the header
  task automatic build_frame(input word_t opc, input word_t len, input bit bad);
    word_t ck;
    int    n;
    frame_buf = {};
    ck = '0;
    add_frame_byte(HASH_CHAR, ck);
    add_frame_byte(HASH_CHAR, ck);
    add_frame_byte(opc[7:0], ck);
    add_frame_byte(opc[15:8], ck);
    add_frame_byte(len[7:0], ck);
    add_frame_byte(len[15:8], ck);
    if (len <= cur_max) begin
      n = frame_body_count(opc, len);
      repeat (n) add_frame_byte(byte_t'($urandom), ck);
      if (bad) ck = ck ^ word_t'($urandom_range(1, 65535));
      frame_buf.push_back(ck[7:0]);
      frame_buf.push_back(ck[15:8]);
    end
  endtask

  task automatic pick_header(output word_t opc, output word_t len);
    int r;
    case ($urandom_range(0, 9))
      0: opc = OPC_NO_ARG;
      1: opc = OPC_RESET;
      2: opc = OPC_TAG;
      3: opc = OPC_STATUS;
      4: opc = OPC_CONFIG;
      5, 6, 7: opc = word_t'($urandom_range(0, 15));
      default: opc = word_t'($urandom);
    endcase
    r = $urandom_range(0, 99);
    if (r < 65) len = word_t'($urandom_range(0, 12));
    else if (r < 80)
      len = (cur_max == 16'hFFFF) ? word_t'($urandom_range(0, 12))
                                  : word_t'($urandom_range(cur_max + 1, 65535));
    else if (r < 90) len = cur_max + word_t'($urandom_range(0, 1));
    else len = word_t'($urandom);
    // keep length-driven payloads short
    if (len <= cur_max && frame_body_count(opc, 16'hFFFF) == 16'hFFFF && len > 60)
      len = word_t'(len[5:0]);
  endtask

  task automatic queue_random(input int budget);
    int    start;
    int    r;
    int    cut;
    word_t opc;
    word_t len;
    byte_t b;
    start = bytes_queued;
    while (bytes_queued - start < budget) begin
      r = $urandom_range(0, 99);
      if (r < 78) begin
        pick_header(opc, len);
        build_frame(opc, len, $urandom_range(0, 99) < 15);
        cut = (r < 70) ? frame_buf.size() : $urandom_range(1, frame_buf.size() - 1);
        for (int i = 0; i < cut; i++) queue_byte(frame_buf[i], 1'b0);
        if (r >= 70 && $urandom_range(0, 3) != 0) queue_byte(byte_t'($urandom), 1'b1);
      end else if (r < 86) begin
        repeat ($urandom_range(1, 4))
          queue_byte(($urandom_range(0, 3) == 0) ? HASH_CHAR : byte_t'($urandom), 1'b0);
      end else if (r < 93) begin
        // broken opening: hash then something else
        queue_byte(HASH_CHAR, 1'b0);
        do b = byte_t'($urandom); while (b == HASH_CHAR);
        queue_byte(b, 1'b0);
      end else begin
        queue_byte(byte_t'($urandom), 1'b1);
      end
    end
  endtask

  task automatic queue_frame(input word_t opc, input word_t len, input bit bad);
    build_frame(opc, len, bad);
    foreach (frame_buf[i]) queue_byte(frame_buf[i], 1'b0);
  endtask

  // sender goes quiet until every expected result is back, then the pipe empties
  task automatic settle();
    while (byte_feed.size() != 0 || in_if.valid || expected_events.size() != 0)
      @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_max_length(input word_t v);
    int target;
    target = cfg_beats + 1;
    cur_max = v;
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.max_length <= v;
    while (cfg_beats != target) @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic set_idle(input int tx_pct, input int rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.rx_byte = '0;
    in_if.timeout = 1'b0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.max_length = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part at the reset limit
    set_idle(24, 48);
    queue_byte(HASH_CHAR, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_frame(OPC_CONFIG, 16'hFFFF, 1'b0);
    queue_byte(HASH_CHAR, 1'b0);
    queue_byte(HASH_CHAR, 1'b0);
    queue_byte(8'hFF, 1'b1);
    queue_frame(OPC_RESET, 16'd0, 1'b0);
    queue_frame(OPC_TAG, MAX_LENGTH_RST, 1'b1);
    queue_random(70);
    settle();

    // every nonzero length rejected
    write_max_length(16'd0);
    queue_random(25);
    settle();

    // widest limit, one payload long enough to wrap the index
    write_max_length(16'hFFFF);
    set_idle(48, 24);
    queue_frame(16'h0003, 16'd1030, 1'b0);
    queue_random(25);
    settle();

    // tight limit, receiver holds off long enough to back up the input
    write_max_length(word_t'($urandom_range(16, 60)));
    set_idle(0, 0);
    queue_random(120);
    rx_hold_req++;
    settle();

    write_max_length(MAX_LENGTH_RST);
    queue_random(30);
    settle();

    if (mismatches == 0 && expected_events.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/fcd_pkg.sv
hdl/fcd_in_if.sv
hdl/fcd_out_if.sv
hdl/fcd_cfg_if.sv
hdl/fcd_front.sv
hdl/fcd_queue.sv
hdl/fcd_back.sv
hdl/framed_command_deframer.sv
dv/tb_top.sv
